// File: rtl/pits_pkg.sv
// shared constants for the point-in-triangle side test
`default_nettype none

package pits_pkg;

    // widths of the stream fields
    localparam int FIELD_WIDTH         = 24;
    localparam int SLOT_WIDTH          = 3;
    localparam int IN_TDATA_WIDTH      = 3 * FIELD_WIDTH;
    localparam int OUT_TDATA_WIDTH     = 8;

    // default coordinate width handed to the top level
    localparam int COORD_WIDTH_DEFAULT = 24;

    // configuration port
    localparam int REG_WIDTH           = 52;
    localparam int CFG_ADDR_WIDTH      = 1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_NEAR_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_EDGE_TOLERANCE = 1'd1;

    // vector slots: point, corners a-c, edges a-c
    localparam int SLOT_COUNT          = 7;
    localparam logic [SLOT_WIDTH-1:0] SLOT_POINT    = 3'd0;
    localparam logic [SLOT_WIDTH-1:0] SLOT_CORNER_A = 3'd1;
    localparam logic [SLOT_WIDTH-1:0] SLOT_EDGE_A   = 3'd4;

    // axis codes
    localparam int AXIS_COUNT          = 3;
    localparam logic [1:0] AXIS_X      = 2'd0;
    localparam logic [1:0] AXIS_Y      = 2'd1;
    localparam logic [1:0] AXIS_Z      = 2'd2;

endpackage

`default_nettype wire

// File: rtl/point_in_triangle_side_test.sv
// point-in-triangle same-side test: vector store, cross pipeline and decision
//
// Seven 3D vectors are loaded one item at a time on the slave stream (tuser picks the slot:
// point, corners a-c, edges a-c; slot 7 stores nothing). An item with tlast set runs the
// test on the stored vectors, its own vector included, and gives one result item: hit in
// tdata bit 0, parallel_edges in tuser. Items without tlast give no result. The work runs
// through a seven-register pipeline (evaluate flag, legs, 24 parallel multipliers,
// cross subtraction, magnitudes, norms and dominant axes, decision), so one item is taken
// every cycle unless input is held off. Input is held off only while an evaluate item
// waits in the first stage behind a stalled pipeline, since that stage reads the vector
// store directly. Vectors come up unknown after reset and must all be written before the
// first evaluate item. Thresholds are unsigned with 16 fraction bits and must be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module point_in_triangle_side_test #(
    parameter int COORD_WIDTH = pits_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration write port
    input  wire logic                                   cfg_we,
    input  wire logic [pits_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  wire logic [pits_pkg::REG_WIDTH-1:0]         cfg_data,
    // input items
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [pits_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,  // x_coord, y_coord, z_coord
    input  wire logic [pits_pkg::SLOT_WIDTH-1:0]        s_tuser,  // slot
    input  wire logic                                   s_tlast,  // evaluate
    // result items
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [pits_pkg::OUT_TDATA_WIDTH-1:0]        m_tdata,  // hit, zero fill
    output logic                                        m_tuser   // parallel_edges
);

    localparam int CW      = (COORD_WIDTH < pits_pkg::FIELD_WIDTH) ?
                             COORD_WIDTH : pits_pkg::FIELD_WIDTH;
    localparam int LEG_W   = CW + 1;
    localparam int PROD_W  = 2 * CW + 1;
    localparam int CROSS_W = 2 * CW + 2;
    localparam int MAG_W   = 2 * CW + 1;
    localparam int L1_W    = MAG_W + 2;
    localparam int RW      = pits_pkg::REG_WIDTH;
    localparam int NA      = pits_pkg::AXIS_COUNT;

    // dominant axis; ties go to the earlier axis, a later axis wins only when strictly larger
    function automatic logic [1:0] dominant(input logic [MAG_W-1:0] mx,
                                            input logic [MAG_W-1:0] my,
                                            input logic [MAG_W-1:0] mz);
        logic [1:0] ax;
        if (mx < my)
            ax = (my < mz) ? pits_pkg::AXIS_Z : pits_pkg::AXIS_Y;
        else
            ax = (mx < mz) ? pits_pkg::AXIS_Z : pits_pkg::AXIS_X;
        return ax;
    endfunction

    // pick one bit of a per-axis flag vector
    function automatic logic pick(input logic [NA-1:0] bits, input logic [1:0] ax);
        logic b;
        case (ax)
            pits_pkg::AXIS_X: b = bits[0];
            pits_pkg::AXIS_Y: b = bits[1];
            pits_pkg::AXIS_Z: b = bits[2];
            default:          b = 1'b0;
        endcase
        return b;
    endfunction

    // configuration registers
    logic [RW-1:0] near_threshold_reg;
    logic [RW-1:0] edge_tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg <= '0;
            edge_tolerance_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pits_pkg::CFG_NEAR_THRESHOLD: near_threshold_reg <= cfg_data;
                pits_pkg::CFG_EDGE_TOLERANCE: edge_tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic ev_valid_reg, lg_valid_reg, mul_valid_reg, crs_valid_reg;
    logic mg_valid_reg, sm_valid_reg, out_valid_reg;
    logic ev_valid_next, lg_valid_next, mul_valid_next, crs_valid_next;
    logic mg_valid_next, sm_valid_next, out_valid_next;
    logic ev_rdy, lg_rdy, mul_rdy, crs_rdy, mg_rdy, sm_rdy, out_rdy;
    logic in_accept;

    assign out_rdy   = !out_valid_reg || m_tready;
    assign sm_rdy    = !sm_valid_reg  || out_rdy;
    assign mg_rdy    = !mg_valid_reg  || sm_rdy;
    assign crs_rdy   = !crs_valid_reg || mg_rdy;
    assign mul_rdy   = !mul_valid_reg || crs_rdy;
    assign lg_rdy    = !lg_valid_reg  || mul_rdy;
    assign ev_rdy    = !ev_valid_reg  || lg_rdy;
    assign s_tready  = ev_rdy;
    assign in_accept = s_tvalid && ev_rdy;

    assign ev_valid_next  = ev_rdy  ? (in_accept && s_tlast) : ev_valid_reg;
    assign lg_valid_next  = lg_rdy  ? ev_valid_reg  : lg_valid_reg;
    assign mul_valid_next = mul_rdy ? lg_valid_reg  : mul_valid_reg;
    assign crs_valid_next = crs_rdy ? mul_valid_reg : crs_valid_reg;
    assign mg_valid_next  = mg_rdy  ? crs_valid_reg : mg_valid_reg;
    assign sm_valid_next  = sm_rdy  ? mg_valid_reg  : sm_valid_reg;
    assign out_valid_next = out_rdy ? sm_valid_reg  : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            lg_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            crs_valid_reg <= 1'b0;
            mg_valid_reg  <= 1'b0;
            sm_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            lg_valid_reg  <= lg_valid_next;
            mul_valid_reg <= mul_valid_next;
            crs_valid_reg <= crs_valid_next;
            mg_valid_reg  <= mg_valid_next;
            sm_valid_reg  <= sm_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // vector store, one row of three components per slot
    logic signed [CW-1:0] store_reg [pits_pkg::SLOT_COUNT][NA];

    for (genvar v = 0; v < pits_pkg::SLOT_COUNT; v++)
    begin : g_store
        for (genvar k = 0; k < NA; k++)
        begin : g_comp
            always_ff @(posedge clk)
            begin
                if (in_accept && s_tuser == pits_pkg::SLOT_WIDTH'(v))
                    store_reg[v][k] <= s_tdata[k*pits_pkg::FIELD_WIDTH +: CW];
            end
        end
    end

    // legs from the point to each corner, edges copied alongside
    logic signed [LEG_W-1:0] leg_reg [NA][NA];
    logic signed [CW-1:0]    edg_reg [NA][NA];

    for (genvar i = 0; i < NA; i++)
    begin : g_leg
        for (genvar k = 0; k < NA; k++)
        begin : g_comp
            always_ff @(posedge clk)
            begin
                if (lg_rdy && ev_valid_reg)
                begin
                    leg_reg[i][k] <= LEG_W'(store_reg[int'(pits_pkg::SLOT_CORNER_A) + i][k])
                                   - LEG_W'(store_reg[int'(pits_pkg::SLOT_POINT)][k]);
                    edg_reg[i][k] <= store_reg[int'(pits_pkg::SLOT_EDGE_A) + i][k];
                end
            end
        end
    end

    // products of all four cross products; row 3 is edge a cross edge b
    logic signed [PROD_W-1:0] prod_p_reg [NA+1][NA];
    logic signed [PROD_W-1:0] prod_n_reg [NA+1][NA];

    for (genvar k = 0; k < NA; k++)
    begin : g_mul
        localparam int K1 = (k + 1) % NA;
        localparam int K2 = (k + 2) % NA;
        for (genvar i = 0; i < NA; i++)
        begin : g_leg_edge
            always_ff @(posedge clk)
            begin
                if (mul_rdy && lg_valid_reg)
                begin
                    prod_p_reg[i][k] <= PROD_W'(leg_reg[i][K1]) * PROD_W'(edg_reg[i][K2]);
                    prod_n_reg[i][k] <= PROD_W'(leg_reg[i][K2]) * PROD_W'(edg_reg[i][K1]);
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (mul_rdy && lg_valid_reg)
            begin
                prod_p_reg[NA][k] <= PROD_W'(edg_reg[0][K1]) * PROD_W'(edg_reg[1][K2]);
                prod_n_reg[NA][k] <= PROD_W'(edg_reg[0][K2]) * PROD_W'(edg_reg[1][K1]);
            end
        end
    end

    // cross components and the parallel-edge check
    logic signed [CROSS_W-1:0] cross_reg [NA][NA];
    logic                      par_crs_reg;
    logic [NA-1:0]             edge_cross_nz;

    for (genvar k = 0; k < NA; k++)
    begin : g_crs
        for (genvar i = 0; i < NA; i++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (crs_rdy && mul_valid_reg)
                    cross_reg[i][k] <= CROSS_W'(prod_p_reg[i][k]) - CROSS_W'(prod_n_reg[i][k]);
            end
        end
        assign edge_cross_nz[k] = (prod_p_reg[NA][k] != prod_n_reg[NA][k]);
    end

    always_ff @(posedge clk)
    begin
        if (crs_rdy && mul_valid_reg)
            par_crs_reg <= (edge_cross_nz == '0);
    end

    // magnitudes, sign and zero flags
    logic [MAG_W-1:0] mag_reg  [NA][NA];
    logic [NA-1:0]    neg_reg  [NA];
    logic [NA-1:0]    zero_reg [NA];
    logic             par_mg_reg;

    for (genvar i = 0; i < NA; i++)
    begin : g_mag
        for (genvar k = 0; k < NA; k++)
        begin : g_comp
            logic [CROSS_W-1:0] abs_val;
            assign abs_val = cross_reg[i][k][CROSS_W-1] ? CROSS_W'(-cross_reg[i][k])
                                                        : CROSS_W'(cross_reg[i][k]);
            always_ff @(posedge clk)
            begin
                if (mg_rdy && crs_valid_reg)
                begin
                    mag_reg[i][k]  <= abs_val[MAG_W-1:0];
                    neg_reg[i][k]  <= cross_reg[i][k][CROSS_W-1];
                    zero_reg[i][k] <= (cross_reg[i][k] == '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mg_rdy && crs_valid_reg)
            par_mg_reg <= par_crs_reg;
    end

    // l1 norms and dominant axes of crosses a and b
    logic [L1_W-1:0] l1a_reg, l1b_reg;
    logic [1:0]      axa_reg, axb_reg;
    logic [NA-1:0]   neg_sm_reg  [NA];
    logic [NA-1:0]   zero_sm_reg [NA];
    logic            par_sm_reg;

    always_ff @(posedge clk)
    begin
        if (sm_rdy && mg_valid_reg)
        begin
            l1a_reg     <= L1_W'(mag_reg[0][0]) + L1_W'(mag_reg[0][1]) + L1_W'(mag_reg[0][2]);
            l1b_reg     <= L1_W'(mag_reg[1][0]) + L1_W'(mag_reg[1][1]) + L1_W'(mag_reg[1][2]);
            axa_reg     <= dominant(mag_reg[0][0], mag_reg[0][1], mag_reg[0][2]);
            axb_reg     <= dominant(mag_reg[1][0], mag_reg[1][1], mag_reg[1][2]);
            neg_sm_reg  <= neg_reg;
            zero_sm_reg <= zero_reg;
            par_sm_reg  <= par_mg_reg;
        end
    end

    // decision
    logic          hit_reg, par_reg;
    logic          hit_next;
    logic [RW-1:0] l1a_ext, l1b_ext;
    logic          ref_a_neg, ref_b_neg;

    assign l1a_ext   = RW'(l1a_reg);
    assign l1b_ext   = RW'(l1b_reg);
    assign ref_a_neg = pick(neg_sm_reg[0], axa_reg);
    assign ref_b_neg = pick(neg_sm_reg[1], axb_reg);

    always_comb
    begin
        if (par_sm_reg)
            hit_next = 1'b0;
        else if (l1a_ext > near_threshold_reg)
        begin
            if (ref_a_neg)
                hit_next = (pick(neg_sm_reg[1], axa_reg) || pick(zero_sm_reg[1], axa_reg))
                        && (pick(neg_sm_reg[2], axa_reg) || pick(zero_sm_reg[2], axa_reg));
            else
                hit_next = !pick(neg_sm_reg[1], axa_reg) && !pick(neg_sm_reg[2], axa_reg);
        end
        else if (l1b_ext < edge_tolerance_reg)
            hit_next = 1'b1;
        else if (ref_b_neg)
            hit_next = pick(neg_sm_reg[2], axb_reg) || pick(zero_sm_reg[2], axb_reg);
        else
            hit_next = !pick(neg_sm_reg[2], axb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && sm_valid_reg)
        begin
            hit_reg <= hit_next;
            par_reg <= par_sm_reg;
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pits_pkg::OUT_TDATA_WIDTH'(hit_reg);
    assign m_tuser  = par_reg;

    // input is held off only by an evaluate item waiting in the first stage
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> ev_valid_reg)
        else $error("input stalled with no evaluate item pending");

    // an accepted evaluate item is pending in the first stage next cycle
    a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> ev_valid_reg)
        else $error("accepted evaluate item lost");

    // a result only appears after the stage before the output held one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(sm_valid_reg))
        else $error("result appeared without a source item");

    // parallel edges never report a hit
    a_par_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[0])
        else $error("hit reported with parallel edges");

endmodule

`default_nettype wire

// File: test/point_in_triangle_side_test_tb.sv
// self-checking testbench for the point-in-triangle side test block
`default_nettype none

module point_in_triangle_side_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [pits_pkg::FIELD_WIDTH-1:0] coord_t;

    typedef struct {
        logic [pits_pkg::SLOT_WIDTH-1:0] slot;
        coord_t                          x;
        coord_t                          y;
        coord_t                          z;
        logic                            evaluate;
    } vec_item_t;

    typedef struct packed {
        logic hit;
        logic parallel_edges;
    } verdict_t;

    localparam coord_t COORD_MAX = coord_t'(8388607);
    localparam coord_t COORD_MIN = coord_t'(-8388608);
    localparam logic [pits_pkg::REG_WIDTH-1:0] REG_MAX = '1;
    localparam logic [pits_pkg::SLOT_WIDTH-1:0] SLOT_CORNER_B = pits_pkg::SLOT_CORNER_A + 3'd1;
    localparam logic [pits_pkg::SLOT_WIDTH-1:0] SLOT_CORNER_C = pits_pkg::SLOT_CORNER_A + 3'd2;
    localparam logic [pits_pkg::SLOT_WIDTH-1:0] SLOT_EDGE_B   = pits_pkg::SLOT_EDGE_A + 3'd1;
    localparam logic [pits_pkg::SLOT_WIDTH-1:0] SLOT_EDGE_C   = pits_pkg::SLOT_EDGE_A + 3'd2;
    localparam logic [pits_pkg::SLOT_WIDTH-1:0] SLOT_UNUSED   = 3'd7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASE_COUNT     = 8;
    localparam int PIPE_SETTLE     = 16;
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 10;

    // predicts the side-test verdict and checks the result items in order
    class triangle_scoreboard;
        logic signed [pits_pkg::FIELD_WIDTH-1:0] vectors[pits_pkg::SLOT_COUNT][3];
        logic [pits_pkg::REG_WIDTH-1:0]          near_thr;
        logic [pits_pkg::REG_WIDTH-1:0]          edge_tol;
        verdict_t                                expected_verdicts[$];
        int                                      mismatches;
        int                                      checked;

        function new();
            near_thr   = '0;
            edge_tol   = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [pits_pkg::CFG_ADDR_WIDTH-1:0] addr,
                              logic [pits_pkg::REG_WIDTH-1:0] value);
            if (addr == pits_pkg::CFG_NEAR_THRESHOLD)
                near_thr = value;
            else
                edge_tol = value;
        endfunction

        function void cross3(input longint a[3], input longint b[3], output longint o[3]);
            o[0] = a[1] * b[2] - a[2] * b[1];
            o[1] = a[2] * b[0] - a[0] * b[2];
            o[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        function longint unsigned magn(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint unsigned norm1(longint v[3]);
            return magn(v[0]) + magn(v[1]) + magn(v[2]);
        endfunction

        // ties go to the earlier axis; a later axis wins only when it is strictly larger
        function logic [1:0] major_axis(longint v[3]);
            longint unsigned mx;
            longint unsigned my;
            longint unsigned mz;
            mx = magn(v[0]);
            my = magn(v[1]);
            mz = magn(v[2]);
            if (mx < my)
                return (my < mz) ? pits_pkg::AXIS_Z : pits_pkg::AXIS_Y;
            return (mx < mz) ? pits_pkg::AXIS_Z : pits_pkg::AXIS_X;
        endfunction

        function verdict_t predict_verdict();
            longint     p[3];
            longint     corner[3][3];
            longint     side[3][3];
            longint     leg[3];
            longint     t[3][3];
            logic [1:0] ax;
            verdict_t   v;
            for (int k = 0; k < 3; k++) begin
                p[k] = vectors[pits_pkg::SLOT_POINT][k];
                for (int i = 0; i < 3; i++) begin
                    corner[i][k] = vectors[pits_pkg::SLOT_CORNER_A + i][k];
                    side[i][k]   = vectors[pits_pkg::SLOT_EDGE_A + i][k];
                end
            end
            // edges a and b parallel: no plane to test against
            cross3(side[0], side[1], t[0]);
            if (t[0][0] == 0 && t[0][1] == 0 && t[0][2] == 0) begin
                v.hit            = 1'b0;
                v.parallel_edges = 1'b1;
                return v;
            end
            v.parallel_edges = 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++)
                    leg[k] = corner[i][k] - p[k];
                cross3(leg, side[i], t[i]);
            end
            // three-way sign test on the dominant axis of cross a
            if (norm1(t[0]) > near_thr) begin
                ax = major_axis(t[0]);
                if (t[0][ax] < 0)
                    v.hit = (t[1][ax] <= 0) && (t[2][ax] <= 0);
                else
                    v.hit = (t[1][ax] >= 0) && (t[2][ax] >= 0);
            end
            // point close to edge b
            else if (norm1(t[1]) < edge_tol)
                v.hit = 1'b1;
            else begin
                ax = major_axis(t[1]);
                if (t[1][ax] < 0)
                    v.hit = (t[2][ax] <= 0);
                else
                    v.hit = (t[2][ax] >= 0);
            end
            return v;
        endfunction

        function void note_vector(vec_item_t it);
            if (it.slot < pits_pkg::SLOT_COUNT) begin
                vectors[it.slot][0] = it.x;
                vectors[it.slot][1] = it.y;
                vectors[it.slot][2] = it.z;
            end
            if (it.evaluate)
                expected_verdicts.push_back(predict_verdict());
        endfunction

        function void check_verdict(logic hit, logic par);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item: hit %0b parallel_edges %0b", hit, par);
                return;
            end
            want = expected_verdicts.pop_front();
            if (hit !== want.hit || par !== want.parallel_edges) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: hit exp %0b got %0b, parallel_edges exp %0b got %0b",
                             checked, want.hit, hit, want.parallel_edges, par);
            end
            checked++;
        endfunction

        function int outstanding();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                                  clk      = 1'b0;
    logic                                  rst_n    = 1'b0;
    logic                                  cfg_we   = 1'b0;
    logic [pits_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr = '0;
    logic [pits_pkg::REG_WIDTH-1:0]        cfg_data = '0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [pits_pkg::IN_TDATA_WIDTH-1:0]   s_tdata  = '0;  // x_coord, y_coord, z_coord
    logic [pits_pkg::SLOT_WIDTH-1:0]       s_tuser  = '0;  // slot
    logic                                  s_tlast  = 1'b0;  // evaluate
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [pits_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata;  // hit, zero fill
    logic                                  m_tuser;  // parallel_edges

    triangle_scoreboard sb = new();

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     stall_cycles   = 0;
    int     items_sent     = 0;
    int     span_bits      = 8;
    coord_t geo[pits_pkg::SLOT_COUNT][3];

    point_in_triangle_side_test dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watch both handshakes at each edge
    always @(posedge clk)
    begin
        vec_item_t it;
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_verdict(m_tdata[0], m_tuser);
            if (s_tvalid && s_tready) begin
                it.slot     = s_tuser;
                it.x        = s_tdata[pits_pkg::FIELD_WIDTH-1:0];
                it.y        = s_tdata[2*pits_pkg::FIELD_WIDTH-1:pits_pkg::FIELD_WIDTH];
                it.z        = s_tdata[3*pits_pkg::FIELD_WIDTH-1:2*pits_pkg::FIELD_WIDTH];
                it.evaluate = s_tlast;
                sb.note_vector(it);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // give up when nothing moves for too long
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    function coord_t span_coord(int bits);
        return coord_t'(int'($urandom_range((2 << bits) - 1)) - (1 << bits));
    endfunction

    function coord_t wild_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return coord_t'(-1);
            4: return coord_t'(1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function logic [pits_pkg::REG_WIDTH-1:0] rand_threshold();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return pits_pkg::REG_WIDTH'(r >> $urandom_range(54, 20));
    endfunction

    // corners in a cube of the given size, edges running a-b-c-a, maybe reversed
    function void build_triangle(int bits);
        bit flip;
        flip      = $urandom_range(1);
        span_bits = bits;
        for (int k = 0; k < 3; k++) begin
            geo[pits_pkg::SLOT_CORNER_A][k] = span_coord(bits);
            geo[SLOT_CORNER_B][k] = span_coord(bits);
            geo[SLOT_CORNER_C][k] = span_coord(bits);
            geo[pits_pkg::SLOT_EDGE_A][k] = geo[SLOT_CORNER_B][k]
                                          - geo[pits_pkg::SLOT_CORNER_A][k];
            geo[SLOT_EDGE_B][k] = geo[SLOT_CORNER_C][k] - geo[SLOT_CORNER_B][k];
            geo[SLOT_EDGE_C][k] = geo[pits_pkg::SLOT_CORNER_A][k] - geo[SLOT_CORNER_C][k];
            if (flip) begin
                geo[pits_pkg::SLOT_EDGE_A][k] = -geo[pits_pkg::SLOT_EDGE_A][k];
                geo[SLOT_EDGE_B][k] = -geo[SLOT_EDGE_B][k];
                geo[SLOT_EDGE_C][k] = -geo[SLOT_EDGE_C][k];
            end
        end
    endfunction

    // point inside, on a corner, on an edge, or anywhere nearby
    function void place_point();
        int wa;
        int wb;
        int wc;
        int i;
        int j;
        wa = $urandom_range(15);
        wb = $urandom_range(15);
        wc = $urandom_range(15);
        if (wa + wb + wc == 0)
            wa = 1;
        i = $urandom_range(2);
        j = (i + 1) % 3;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
                for (int k = 0; k < 3; k++)
                    geo[pits_pkg::SLOT_POINT][k] =
                        coord_t'((wa * int'(geo[pits_pkg::SLOT_CORNER_A][k])
                        + wb * int'(geo[SLOT_CORNER_B][k])
                        + wc * int'(geo[SLOT_CORNER_C][k])) / (wa + wb + wc));
            5:
                for (int k = 0; k < 3; k++)
                    geo[pits_pkg::SLOT_POINT][k] = geo[pits_pkg::SLOT_CORNER_A + i][k];
            6:
                for (int k = 0; k < 3; k++)
                    geo[pits_pkg::SLOT_POINT][k] =
                        coord_t'((int'(geo[pits_pkg::SLOT_CORNER_A + i][k])
                        + int'(geo[pits_pkg::SLOT_CORNER_A + j][k])) / 2);
            default:
                for (int k = 0; k < 3; k++)
                    geo[pits_pkg::SLOT_POINT][k] = span_coord(span_bits + 1);
        endcase
    endfunction

    // one input item, with random idle cycles ahead of it
    task automatic put(input logic [pits_pkg::SLOT_WIDTH-1:0] slot, input coord_t x,
                       input coord_t y, input coord_t z, input logic eval);
        if (slot < pits_pkg::SLOT_COUNT) begin
            geo[slot][0] = x;
            geo[slot][1] = y;
            geo[slot][2] = z;
        end
        if (slot < pits_pkg::SLOT_COUNT || eval)
            items_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= slot;
        s_tdata  <= {z, y, x};
        s_tlast  <= eval;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // load some of the stored geometry in random order, evaluate on the last item
    task automatic send_triangle(input int count);
        int order[pits_pkg::SLOT_COUNT];
        int j;
        int tmp;
        logic [pits_pkg::SLOT_WIDTH-1:0] s;
        for (int i = 0; i < pits_pkg::SLOT_COUNT; i++)
            order[i] = i;
        for (int i = pits_pkg::SLOT_COUNT - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < count; i++) begin
            s = pits_pkg::SLOT_WIDTH'(order[i]);
            put(s, geo[s][0], geo[s][1], geo[s][2], i == count - 1);
        end
    endtask

    // stop sending and let every expected result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [pits_pkg::REG_WIDTH-1:0] near,
                                  input logic [pits_pkg::REG_WIDTH-1:0] tol);
        cfg_we   <= 1'b1;
        cfg_addr <= pits_pkg::CFG_NEAR_THRESHOLD;
        cfg_data <= near;
        @(posedge clk);
        sb.set_reg(pits_pkg::CFG_NEAR_THRESHOLD, near);
        cfg_addr <= pits_pkg::CFG_EDGE_TOLERANCE;
        cfg_data <= tol;
        @(posedge clk);
        sb.set_reg(pits_pkg::CFG_EDGE_TOLERANCE, tol);
        cfg_we <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // triangle with normal along (1,1,1): equal-magnitude axis ties
        put(pits_pkg::SLOT_CORNER_A, 256, 0, 0, 1'b0);
        put(SLOT_CORNER_B, 0, 256, 0, 1'b0);
        put(SLOT_CORNER_C, 0, 0, 256, 1'b0);
        put(pits_pkg::SLOT_EDGE_A, -256, 256, 0, 1'b0);
        put(SLOT_EDGE_B, 0, -256, 256, 1'b0);
        put(SLOT_EDGE_C, 256, 0, -256, 1'b0);
        put(pits_pkg::SLOT_POINT, 85, 85, 85, 1'b1);
        // outside, on corner a (zero leg), on an edge midpoint
        put(pits_pkg::SLOT_POINT, 512, -256, 0, 1'b1);
        put(pits_pkg::SLOT_POINT, 256, 0, 0, 1'b1);
        put(pits_pkg::SLOT_POINT, 128, 128, 0, 1'b1);
        // unused slot stores nothing but still evaluates
        put(SLOT_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        // parallel edges: same direction, then a zero edge
        put(SLOT_EDGE_B, -256, 256, 0, 1'b1);
        put(SLOT_EDGE_B, 0, 0, 0, 1'b1);
        // coordinate extremes
        put(pits_pkg::SLOT_EDGE_A, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        put(SLOT_EDGE_B, COORD_MIN, COORD_MAX, COORD_MIN + 1, 1'b0);
        put(pits_pkg::SLOT_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        put(pits_pkg::SLOT_CORNER_A, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_thresholds('0, REG_MAX);
                1: set_thresholds(REG_MAX, '0);
                2: set_thresholds(REG_MAX, REG_MAX);
                4: set_thresholds('0, '0);
                default: set_thresholds(rand_threshold(), rand_threshold());
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                case ($urandom_range(19))
                    // whole new triangle and point
                    0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                        build_triangle($urandom_range(21, 4));
                        place_point();
                        send_triangle(pits_pkg::SLOT_COUNT);
                    end
                    // move only the point
                    9, 10, 11, 12: begin
                        place_point();
                        put(pits_pkg::SLOT_POINT, geo[pits_pkg::SLOT_POINT][0],
                            geo[pits_pkg::SLOT_POINT][1], geo[pits_pkg::SLOT_POINT][2],
                            1'b1);
                    end
                    // edge b parallel to edge a, or zero
                    13, 14: begin
                        k = int'($urandom_range(2)) - 1;
                        put(SLOT_EDGE_B, coord_t'(k * int'(geo[pits_pkg::SLOT_EDGE_A][0])),
                            coord_t'(k * int'(geo[pits_pkg::SLOT_EDGE_A][1])),
                            coord_t'(k * int'(geo[pits_pkg::SLOT_EDGE_A][2])), 1'b1);
                    end
                    // partial reload
                    15, 16: begin
                        build_triangle($urandom_range(21, 4));
                        place_point();
                        send_triangle($urandom_range(pits_pkg::SLOT_COUNT - 1, 1));
                    end
                    // noise anywhere, including the unused slot
                    default:
                        put(pits_pkg::SLOT_WIDTH'($urandom_range(7)), wild_coord(),
                            wild_coord(), wild_coord(), $urandom_range(99) < 40);
                endcase
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
